// ===== rtl/mpb_pkg.sv =====
// mpb_pkg: shared constants and word types for the median price block
// used by mpb_front, mpb_back, mpb_sort and median_price_of_batch; no dependencies

package mpb_pkg;

    // store geometry
    localparam int MAX_RECORDS = 64;
    localparam int PRICE_BITS  = 32;
    localparam int COUNT_BITS  = $clog2(MAX_RECORDS + 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // record kinds
    localparam logic DOC_OFFER = 1'b0;
    localparam logic DOC_MODEL = 1'b1;

    typedef logic [PRICE_BITS-1:0] price_t;

    // input word: one price record
    typedef struct packed {
        logic        doc_kind;
        logic        has_main_price;
        logic [31:0] main_price;
        logic        has_min_price;
        logic [31:0] min_price;
        logic        last_record;
    } rec_word_t;

    // output word: batch median
    typedef struct packed {
        logic [31:0] median_price;
        logic        overflow;
    } med_word_t;

    // queued word: chosen price and end-of-batch mark
    typedef struct packed {
        price_t price;
        logic   last;
    } queue_word_t;

endpackage

// ===== rtl/mpb_front.sv =====
// mpb_front: picks the price of each record and queues it for the sorter
// depends on mpb_pkg

module mpb_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_valid,
    output logic                 rec_stall,
    input  mpb_pkg::rec_word_t   rec,
    output logic                 q_valid,
    input  logic                 q_stall,
    output mpb_pkg::queue_word_t q_word
);

    mpb_pkg::queue_word_t               mem_reg [mpb_pkg::QUEUE_DEPTH];
    logic [mpb_pkg::QPTR_BITS-1:0]      wr_ptr_reg;
    logic [mpb_pkg::QPTR_BITS-1:0]      wr_ptr_next;
    logic [mpb_pkg::QPTR_BITS-1:0]      rd_ptr_reg;
    logic [mpb_pkg::QPTR_BITS-1:0]      rd_ptr_next;
    logic [mpb_pkg::QCNT_BITS-1:0]      fill_reg;
    logic [mpb_pkg::QCNT_BITS-1:0]      fill_next;
    mpb_pkg::queue_word_t               push_word;
    logic                               push;
    logic                               pop;

    // price selection per record kind
    always_comb
    begin
        push_word.last = rec.last_record;
        if (rec.has_main_price)
        begin
            push_word.price = mpb_pkg::PRICE_BITS'(rec.main_price);
        end
        else if (rec.doc_kind == mpb_pkg::DOC_MODEL || rec.has_min_price)
        begin
            push_word.price = mpb_pkg::PRICE_BITS'(rec.min_price);
        end
        else
        begin
            push_word.price = '0;
        end
    end

    // queue handshake
    assign rec_stall = (fill_reg == mpb_pkg::QCNT_BITS'(mpb_pkg::QUEUE_DEPTH));
    assign push      = rec_valid && !rec_stall;
    assign q_valid   = (fill_reg != '0);
    assign pop       = q_valid && !q_stall;
    assign q_word    = mem_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== rtl/mpb_back.sv =====
// mpb_back: back part of the median price block, sorter behind the queue
// depends on mpb_pkg and mpb_sort

module mpb_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_stall,
    input  mpb_pkg::queue_word_t q_word,
    output logic                 med_valid,
    input  logic                 med_stall,
    output mpb_pkg::med_word_t   med
);

    // sorted store, batch control and median output word
    mpb_sort u_sort
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_stall   (q_stall),
        .q_word    (q_word),
        .med_valid (med_valid),
        .med_stall (med_stall),
        .med       (med)
    );

endmodule

// ===== rtl/mpb_sort.sv =====
// mpb_sort: systolic sorted insert of queued prices and median readout
// depends on mpb_pkg

module mpb_sort
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_stall,
    input  mpb_pkg::queue_word_t q_word,
    output logic                 med_valid,
    input  logic                 med_stall,
    output mpb_pkg::med_word_t   med
);

    typedef enum logic [2:0] {
        S_RUN   = 3'b001,
        S_SHIFT = 3'b010,
        S_EMIT  = 3'b100
    } state_t;

    localparam int IDX_B = (mpb_pkg::MAX_RECORDS > 1) ? 1 : 0;

    state_t                             state_reg;
    state_t                             state_next;
    mpb_pkg::price_t                    cell_reg  [mpb_pkg::MAX_RECORDS];
    mpb_pkg::price_t                    cell_next [mpb_pkg::MAX_RECORDS];
    logic [mpb_pkg::MAX_RECORDS-1:0]    gt;
    logic [mpb_pkg::COUNT_BITS-1:0]     count_reg;
    logic [mpb_pkg::COUNT_BITS-1:0]     count_next;
    logic [mpb_pkg::COUNT_BITS-1:0]     shift_reg;
    logic [mpb_pkg::COUNT_BITS-1:0]     shift_next;
    logic [mpb_pkg::COUNT_BITS-1:0]     half;
    logic                               ovf_reg;
    logic                               ovf_next;
    logic                               accept;
    logic                               full;
    logic                               do_insert;
    logic                               load_out;
    logic                               med_valid_reg;
    logic                               med_valid_next;
    mpb_pkg::med_word_t                 med_reg;
    mpb_pkg::price_t                    mid_a;
    mpb_pkg::price_t                    mid_b;
    mpb_pkg::price_t                    median;

    // handshakes
    assign q_stall   = (state_reg != S_RUN);
    assign accept    = q_valid && !q_stall;
    assign full      = (count_reg == mpb_pkg::COUNT_BITS'(mpb_pkg::MAX_RECORDS));
    assign do_insert = accept && !full;
    assign load_out  = (state_reg == S_EMIT) && (!med_valid_reg || !med_stall);
    assign med_valid = med_valid_reg;
    assign med       = med_reg;

    // per-cell compare against the incoming price, strict so ties go after
    always_comb
    begin
        for (int i = 0; i < mpb_pkg::MAX_RECORDS; i++)
        begin
            gt[i] = (mpb_pkg::COUNT_BITS'(i) < count_reg) && (cell_reg[i] > q_word.price);
        end
    end

    // cell update: insert with shift up, or shift down while seeking the middle
    always_comb
    begin
        for (int i = 0; i < mpb_pkg::MAX_RECORDS; i++)
        begin
            cell_next[i] = cell_reg[i];
        end
        if (do_insert)
        begin
            if (gt[0] || count_reg == '0)
            begin
                cell_next[0] = q_word.price;
            end
            for (int i = 1; i < mpb_pkg::MAX_RECORDS; i++)
            begin
                if (gt[i-1] && mpb_pkg::COUNT_BITS'(i) <= count_reg)
                begin
                    cell_next[i] = cell_reg[i-1];
                end
                else if (gt[i] || mpb_pkg::COUNT_BITS'(i) == count_reg)
                begin
                    cell_next[i] = q_word.price;
                end
            end
        end
        else if (state_reg == S_SHIFT && shift_reg != '0)
        begin
            for (int i = 0; i < mpb_pkg::MAX_RECORDS - 1; i++)
            begin
                cell_next[i] = cell_reg[i+1];
            end
        end
    end

    // median after the shift down: front cell for an odd count, else mean of the two front cells; zero given as 1
    always_comb
    begin
        mid_a = cell_reg[0];
        mid_b = cell_reg[IDX_B];
        if (count_reg[0])
        begin
            median = mid_a;
        end
        else
        begin
            median = (mid_a >> 1) + (mid_b >> 1)
                   + mpb_pkg::PRICE_BITS'(mid_a[0] & mid_b[0]);
        end
        if (median == '0)
        begin
            median = mpb_pkg::PRICE_BITS'(1);
        end
    end

    // batch control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        shift_next     = shift_reg;
        med_valid_next = med_valid_reg;
        half           = '0;
        if (med_valid_reg && !med_stall)
        begin
            med_valid_next = 1'b0;
        end
        case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (q_word.last)
                    begin
                        half       = count_next >> 1;
                        shift_next = count_next[0] ? half : half - 1'b1;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                if (shift_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    shift_next = shift_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                if (load_out)
                begin
                    med_valid_next = 1'b1;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            shift_reg     <= '0;
            med_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            shift_reg     <= shift_next;
            med_valid_reg <= med_valid_next;
        end
    end

    // sorted cells and output word
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mpb_pkg::MAX_RECORDS; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        if (load_out)
        begin
            med_reg.median_price <= 32'(median);
            med_reg.overflow     <= ovf_reg;
        end
    end

endmodule

// ===== rtl/median_price_of_batch.sv =====
// median_price_of_batch: median of a batch of price records
// depends on mpb_pkg, mpb_front, mpb_back, mpb_sort
// throughput: one record per cycle within a batch, unless the queue is full or the sorter is busy
// closing a batch adds a shift-down in S_SHIFT and a readout into the output word in S_EMIT
// last record to median word: queue, sorted insert, shift-down, then readout when the output is free
// reset: rst_n async active low empties queue, count, overflow flag and output valid flag

module median_price_of_batch
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_valid,
    output logic               rec_stall,
    input  mpb_pkg::rec_word_t rec,
    output logic               med_valid,
    input  logic               med_stall,
    output mpb_pkg::med_word_t med
);

    logic                 q_valid;
    logic                 q_stall;
    mpb_pkg::queue_word_t q_word;

    // front: price selection and queue
    mpb_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec),
        .q_valid   (q_valid),
        .q_stall   (q_stall),
        .q_word    (q_word)
    );

    // back: sorted store and median
    mpb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_stall   (q_stall),
        .q_word    (q_word),
        .med_valid (med_valid),
        .med_stall (med_stall),
        .med       (med)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for median_price_of_batch, directed batches then random ones
// depends on mpb_pkg and the median_price_of_batch rtl

module tb;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 100;
    localparam int RAND_ITEMS  = 1250;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               rec_valid = 1'b0;
    logic               rec_stall;
    mpb_pkg::rec_word_t rec = '0;
    logic               med_valid;
    logic               med_stall = 1'b0;
    mpb_pkg::med_word_t med;

    // pending input words and expected output words
    mpb_pkg::rec_word_t record_q[$];
    mpb_pkg::med_word_t median_q[$];

    // predictor state: prices of the open batch, kept ascending
    mpb_pkg::price_t    batch_prices[$];
    logic               batch_dropped = 1'b0;

    int          errors = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    logic [31:0] cyc = '0;
    logic        calm = 1'b0;

    median_price_of_batch dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec),
        .med_valid (med_valid),
        .med_stall (med_stall),
        .med       (med)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // append one word to the pending input words
    task automatic add_rec(input mpb_pkg::rec_word_t r);
        record_q.insert(record_q.size(), r);
    endtask

    // idle length: mostly none or short, a few long, none in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic mpb_pkg::rec_word_t make_rec(input logic kind, input logic hm,
                                                    input mpb_pkg::price_t mp,
                                                    input logic hn,
                                                    input mpb_pkg::price_t np,
                                                    input logic last);
        mpb_pkg::rec_word_t r;
        r.doc_kind       = kind;
        r.has_main_price = hm;
        r.main_price     = mp;
        r.has_min_price  = hn;
        r.min_price      = np;
        r.last_record    = last;
        return r;
    endfunction

    // price mix: full range, small values for ties, zero and the top end
    function automatic mpb_pkg::price_t rand_price();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        if (r < 7)
            return $urandom_range(0, 15);
        if (r == 7)
            return '0;
        if (r == 8)
            return '1;
        return 32'hFFFF_FFF0 | $urandom_range(0, 15);
    endfunction

    // add one accepted record to the batch and predict the median on the closing one
    task automatic fold_record(input mpb_pkg::rec_word_t r);
        mpb_pkg::price_t    p;
        mpb_pkg::price_t    a;
        mpb_pkg::price_t    b;
        mpb_pkg::price_t    m;
        mpb_pkg::med_word_t w;
        int                 pos;
        int                 n;
        if (r.has_main_price)
            p = r.main_price;
        else if (r.doc_kind == mpb_pkg::DOC_MODEL || r.has_min_price)
            p = r.min_price;
        else
            p = '0;
        // sorted insert, equal prices go after the stored ones
        if (batch_prices.size() < mpb_pkg::MAX_RECORDS)
        begin
            pos = batch_prices.size();
            while (pos > 0 && batch_prices[pos-1] > p)
                pos--;
            batch_prices.insert(pos, p);
        end
        else
            batch_dropped = 1'b1;
        if (r.last_record)
        begin
            n = batch_prices.size();
            if (n % 2 == 1)
                m = batch_prices[n/2];
            else
            begin
                a = batch_prices[n/2 - 1];
                b = batch_prices[n/2];
                m = (a >> 1) + (b >> 1) + (a & b & 1);
            end
            if (m == '0)
                m = 1;
            w.median_price = m;
            w.overflow     = batch_dropped;
            median_q.insert(median_q.size(), w);
            batch_prices.delete();
            batch_dropped = 1'b0;
        end
    endtask

    task automatic check_median(input mpb_pkg::med_word_t got);
        mpb_pkg::med_word_t want;
        if (median_q.size() == 0)
        begin
            report($sformatf("unexpected median word %h", got));
            return;
        end
        want = median_q.pop_front();
        if (got.median_price !== want.median_price)
            report($sformatf("median_price %h, expected %h", got.median_price,
                             want.median_price));
        if (got.overflow !== want.overflow)
            report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
    endtask

    // calm stretches with no idling on either side
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc[7:0] == 8'd0)
            calm <= ($urandom_range(0, 3) == 0);
    end

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rec_valid <= 1'b0;
            gap_left  <= 0;
        end
        else
        begin
            if (rec_valid && !rec_stall)
                fold_record(rec);
            if (!rec_valid || !rec_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left  <= gap_left - 1;
                    rec_valid <= 1'b0;
                end
                else if (record_q.size() > 0)
                begin
                    rec       <= record_q.pop_front();
                    rec_valid <= 1'b1;
                    gap_left  <= pick_gap();
                end
                else
                    rec_valid <= 1'b0;
            end
        end
    end

    // output stall and monitor
    always @(posedge clk)
    begin : out_side
        int n;
        if (rst_n && med_valid && !med_stall)
            check_median(med);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            med_stall <= 1'b1;
        end
        else
        begin
            n = pick_gap();
            if (n > 0 && $urandom_range(0, 3) == 0)
            begin
                med_stall <= 1'b1;
                hold_left <= n - 1;
            end
            else
                med_stall <= 1'b0;
        end
    end

    // cycles without any word moving
    always @(posedge clk)
    begin
        if (!rst_n || (rec_valid && !rec_stall) || (med_valid && !med_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        int size;
        int batches;
        int r;

        // single zero price, median of 0 given as 1
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b1, 32'h0, 1'b0, 32'h0, 1'b1));
        // top price with a min present, main wins
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b1, '1, 1'b1, 32'h0, 1'b1));
        // every price choice: offer min, offer none, model min ignoring flag, model main
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b0, '1, 1'b1, 32'd7, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b0, '1, 1'b0, '1, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_MODEL, 1'b0, '1, 1'b0, 32'd5, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_MODEL, 1'b1, 32'd9, 1'b1, 32'd1, 1'b1));
        // even mean at the top end, no carry out
        add_rec(make_rec(mpb_pkg::DOC_MODEL, 1'b1, '1, 1'b0, 32'h0, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b1, 32'hFFFF_FFFE, 1'b0, 32'h0, 1'b1));
        // equal prices
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b1, 32'd3, 1'b0, 32'h0, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_MODEL, 1'b0, 32'h0, 1'b0, 32'd3, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b0, 32'h0, 1'b1, 32'd3, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b1, 32'd1, 1'b0, 32'h0, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_MODEL, 1'b1, 32'd3, 1'b1, 32'd8, 1'b1));
        // even count of zeros
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b0, 32'd4, 1'b0, 32'd4, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_MODEL, 1'b0, 32'd4, 1'b1, 32'h0, 1'b1));
        // truncated mean of an odd sum
        add_rec(make_rec(mpb_pkg::DOC_OFFER, 1'b1, 32'd2, 1'b1, 32'd2, 1'b0));
        add_rec(make_rec(mpb_pkg::DOC_MODEL, 1'b1, 32'd1, 1'b1, 32'd1, 1'b1));

        // random batches: first a full store, one dropped closing record, three dropped records, then mostly short
        batches = 0;
        while (record_q.size() < RAND_ITEMS)
        begin
            if (batches == 0)
                size = mpb_pkg::MAX_RECORDS;
            else if (batches == 1)
                size = mpb_pkg::MAX_RECORDS + 1;
            else if (batches == 2)
                size = mpb_pkg::MAX_RECORDS + 3;
            else
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    size = $urandom_range(mpb_pkg::MAX_RECORDS - 4,
                                          mpb_pkg::MAX_RECORDS + 6);
                else
                    size = $urandom_range(1, 12);
            end
            for (int i = 0; i < size; i++)
                add_rec(make_rec(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 rand_price(), 1'($urandom_range(0, 1)), rand_price(),
                                 i == size - 1));
            batches++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all words to go in and all medians to come out
        @(negedge clk);
        while (record_q.size() != 0 || rec_valid || median_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (median_q.size() != 0)
            report($sformatf("%0d median words never arrived", median_q.size()));
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
